>>> rtl/gbcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbcd_pkg
// Shared types and constants of the grid boundary cell detector.
// ----------------------------------------------------------------------------
package gbcd_pkg;

    localparam int CFG_W   = 11;
    localparam int CLS_W   = 2;
    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int NRES    = 4;

    // decision queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;
    localparam int QLW     = 3;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_COLS = 2'd2;

    // cell classes
    localparam logic [CLS_W-1:0] CLS_ZERO = 2'd0;
    localparam int               CLS_NEG_BIT = 1;

    localparam logic MODE_OBSTACLE = 1'b0;

    typedef struct packed {
        logic             mode;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
    } cfg_t;

    // decisions caused by one item, in raster order:
    // up-left, up (last column), left (last row), centre (final cell)
    typedef struct packed {
        logic [NRES-1:0]  mask;
        logic [NRES-1:0]  hits;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } bundle_t;

endpackage
`default_nettype wire

>>> rtl/gbcd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbcd interfaces
// Cell stream and decision stream channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbcd_in_if;
    import gbcd_pkg::*;
    logic             valid;
    logic             ready;
    logic [CLS_W-1:0] cell_class;

    modport source (output valid, output cell_class, input ready);
    modport sink   (input valid, input cell_class, output ready);
endinterface

interface gbcd_out_if;
    import gbcd_pkg::*;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic             run_last;
    logic             frame_end;

    modport source (output valid, output hit, output cell_row, output cell_col,
                    output run_last, output frame_end, input ready);
    modport sink   (input valid, input hit, input cell_row, input cell_col,
                    input run_last, input frame_end, output ready);
endinterface
`default_nettype wire

>>> rtl/gbcd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbcd_front
// Accepts cells, keeps the row memory and the 3x3 window, and classifies
// the decisions each item causes into one bundle for the queue.
// ----------------------------------------------------------------------------
module gbcd_front #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  gbcd_pkg::cfg_t            cfg,
    gbcd_in_if.sink                   cells,
    input  wire [gbcd_pkg::QLW-1:0]   queue_level,
    output logic                      push,
    output gbcd_pkg::bundle_t         push_data
);
    import gbcd_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RLW = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
    localparam int CLW = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

    typedef logic [2:0][2:0][CLS_W-1:0] win_t;

    function automatic logic is_zero(logic [CLS_W-1:0] v);
        return v == CLS_ZERO;
    endfunction

    function automatic logic is_neg(logic [CLS_W-1:0] v);
        return v[CLS_NEG_BIT];
    endfunction

    // centre at window (cr,cc); edge flags say which neighbour rows/cols lie in the grid
    function automatic logic decide(win_t w, logic md, int cr, int cc,
                                    logic top, logic bot, logic left, logic right);
        logic found;
        logic ok;
        logic centre_ok;
        found = 1'b0;
        centre_ok = (md == MODE_OBSTACLE) ? is_zero(w[cr][cc]) : is_neg(w[cr][cc]);
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                ok = !(dr == 0 && dc == 0)
                     && (dr != -1 || top) && (dr != 1 || bot)
                     && (dc != -1 || left) && (dc != 1 || right)
                     && (cr + dr >= 0) && (cr + dr <= 2)
                     && (cc + dc >= 0) && (cc + dc <= 2);
                if (ok) begin
                    if ((md == MODE_OBSTACLE) ? !is_zero(w[cr + dr][cc + dc])
                                              : is_zero(w[cr + dr][cc + dc]))
                        found = 1'b1;
                end
            end
        end
        return centre_ok && found;
    endfunction

    // grid size, clamped to the supported range
    logic [RLW-1:0] rows_ext, rows_lim;
    logic [CLW-1:0] cols_ext, cols_lim;
    logic [RW-1:0]  rows_m1;
    logic [CW-1:0]  cols_m1;

    always_comb
    begin
        rows_ext = RLW'(cfg.rows);
        cols_ext = CLW'(cfg.cols);
        if (rows_ext < RLW'(2))
            rows_lim = RLW'(2);
        else if (rows_ext > RLW'(MAX_ROWS))
            rows_lim = RLW'(MAX_ROWS);
        else
            rows_lim = rows_ext;
        if (cols_ext < CLW'(2))
            cols_lim = CLW'(2);
        else if (cols_ext > CLW'(MAX_COLS))
            cols_lim = CLW'(MAX_COLS);
        else
            cols_lim = cols_ext;
        rows_m1 = RW'(rows_lim - RLW'(1));
        cols_m1 = CW'(cols_lim - CLW'(1));
    end

    // stage A: accept, position, memory read
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] r_cur;
    logic [CW-1:0] c_cur;
    logic          last_row, last_col;
    logic          accept;
    logic [QLW:0]  occupancy;

    // stage B: window shift, memory write-back, decisions
    logic             b_valid_reg;
    logic [CLS_W-1:0] b_cls_reg;
    logic [RW-1:0]    b_row_reg;
    logic [CW-1:0]    b_col_reg;
    logic             b_last_row_reg;
    logic             b_last_col_reg;
    logic [2*CLS_W-1:0] rd_reg;
    win_t             win_reg, win_next;

    // {upper, middle} class per column
    logic [2*CLS_W-1:0] row_mem [MAX_COLS];

    assign occupancy   = (QLW + 1)'(queue_level) + (QLW + 1)'(b_valid_reg);
    assign cells.ready = occupancy < (QLW + 1)'(QDEPTH);
    assign accept      = cells.valid && cells.ready;

    always_comb
    begin
        r_cur    = (row_reg >= rows_m1) ? rows_m1 : row_reg;
        c_cur    = (col_reg >= cols_m1) ? cols_m1 : col_reg;
        last_row = r_cur == rows_m1;
        last_col = c_cur == cols_m1;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : r_cur + RW'(1);
        end
        else
        begin
            col_next = c_cur + CW'(1);
            row_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            b_valid_reg <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            b_valid_reg <= accept;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (b_valid_reg)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_cls_reg      <= cells.cell_class;
            b_row_reg      <= r_cur;
            b_col_reg      <= c_cur;
            b_last_row_reg <= last_row;
            b_last_col_reg <= last_col;
        end
    end

    // with the size unchanged, consecutive items never share a column, so read and write-back never collide
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= row_mem[c_cur];
        if (b_valid_reg)
            row_mem[b_col_reg] <= {rd_reg[CLS_W-1:0], b_cls_reg};
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = rd_reg[2*CLS_W-1:CLS_W];
        win_next[1][2] = rd_reg[CLS_W-1:0];
        win_next[2][2] = b_cls_reg;
    end

    logic r_ge1, r_ge2, c_ge1, c_ge2;
    logic [NRES-1:0] mask, hits;

    always_comb
    begin
        r_ge1 = b_row_reg != '0;
        r_ge2 = b_row_reg > RW'(1);
        c_ge1 = b_col_reg != '0;
        c_ge2 = b_col_reg > CW'(1);
        mask[0] = r_ge1 && c_ge1;
        mask[1] = r_ge1 && b_last_col_reg;
        mask[2] = b_last_row_reg && c_ge1;
        mask[3] = b_last_row_reg && b_last_col_reg;
        hits[0] = decide(win_next, cfg.mode, 1, 1, r_ge2, 1'b1, c_ge2, 1'b1);
        hits[1] = decide(win_next, cfg.mode, 1, 2, r_ge2, 1'b1, 1'b1, 1'b0);
        hits[2] = decide(win_next, cfg.mode, 2, 1, 1'b1, 1'b0, c_ge2, 1'b1);
        hits[3] = decide(win_next, cfg.mode, 2, 2, 1'b1, 1'b0, 1'b1, 1'b0);
    end

    assign push           = b_valid_reg && (mask != '0);
    assign push_data.mask = mask;
    assign push_data.hits = hits;
    assign push_data.row  = ROW_W'(b_row_reg);
    assign push_data.col  = COL_W'(b_col_reg);

endmodule
`default_nettype wire

>>> rtl/gbcd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbcd_queue
// Short queue of decision bundles between the front and the back.
// ----------------------------------------------------------------------------
module gbcd_queue (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  gbcd_pkg::bundle_t       push_data,
    input  wire                     pop,
    output logic                    q_valid,
    output gbcd_pkg::bundle_t       q_data,
    output logic [gbcd_pkg::QLW-1:0] level
);
    import gbcd_pkg::*;

    bundle_t         slot_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg;
    logic [QAW-1:0]  rd_ptr_reg;
    logic [QLW-1:0]  level_reg, level_next;

    assign q_valid = level_reg != '0;
    assign q_data  = slot_reg[rd_ptr_reg];
    assign level   = level_reg;

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
            level_next = level_reg + QLW'(1);
        else if (pop && !push)
            level_next = level_reg - QLW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> level_reg < QLW'(QDEPTH))
        else $error("queue written while full");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> level_reg != '0)
        else $error("queue read while empty");

    a_push_seen : assert property (@(posedge clk) disable iff (!rst_n)
        push && level_reg == '0 |=> q_valid)
        else $error("pushed bundle not visible");
`endif

endmodule
`default_nettype wire

>>> rtl/gbcd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbcd_back
// Unpacks decision bundles into single results behind an output register.
// ----------------------------------------------------------------------------
module gbcd_back (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               q_valid,
    input  gbcd_pkg::bundle_t q_data,
    output logic              pop,
    gbcd_out_if.source        decisions
);
    import gbcd_pkg::*;

    logic             cur_valid_reg;
    bundle_t          cur_reg;
    logic             out_valid_reg;
    logic             hit_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             run_last_reg;
    logic             frame_end_reg;

    logic             can_emit, emit, emit_last;
    logic [NRES-1:0]  pick, rest;
    logic             sel_hit, sel_frame_end;
    logic [ROW_W-1:0] sel_row;
    logic [COL_W-1:0] sel_col;

    always_comb
    begin
        pick = '0;
        if (cur_reg.mask[0])
            pick[0] = 1'b1;
        else if (cur_reg.mask[1])
            pick[1] = 1'b1;
        else if (cur_reg.mask[2])
            pick[2] = 1'b1;
        else
            pick[3] = 1'b1;
        rest      = cur_reg.mask & ~pick;
        emit_last = rest == '0;
        sel_hit   = |(cur_reg.hits & pick);
        // first two results belong to the row above, odd ones to this column
        sel_row   = (pick[0] || pick[1]) ? cur_reg.row - ROW_W'(1) : cur_reg.row;
        sel_col   = (pick[0] || pick[2]) ? cur_reg.col - COL_W'(1) : cur_reg.col;
        sel_frame_end = pick[3];
    end

    assign can_emit = !out_valid_reg || decisions.ready;
    assign emit     = cur_valid_reg && can_emit;
    assign pop      = q_valid && (!cur_valid_reg || (emit && emit_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                cur_valid_reg <= 1'b1;
            else if (emit && emit_last)
                cur_valid_reg <= 1'b0;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (decisions.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_data;
        else if (emit)
            cur_reg.mask <= rest;
        if (emit)
        begin
            hit_reg       <= sel_hit;
            row_reg       <= sel_row;
            col_reg       <= sel_col;
            run_last_reg  <= emit_last;
            frame_end_reg <= sel_frame_end;
        end
    end

    assign decisions.valid     = out_valid_reg;
    assign decisions.hit       = hit_reg;
    assign decisions.cell_row  = row_reg;
    assign decisions.cell_col  = col_reg;
    assign decisions.run_last  = run_last_reg;
    assign decisions.frame_end = frame_end_reg;

`ifndef NO_ASSERTIONS
    a_frame_end_last : assert property (@(posedge clk) disable iff (!rst_n)
        decisions.valid && decisions.frame_end |-> decisions.run_last)
        else $error("final cell result not last of its item");

    a_bundle_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_reg.mask != '0)
        else $error("held bundle has no results left");

    a_run_continues : assert property (@(posedge clk) disable iff (!rst_n)
        decisions.valid && decisions.ready && !decisions.run_last |=> decisions.valid)
        else $error("gap inside the results of one item");
`endif

endmodule
`default_nettype wire

>>> rtl/grid_boundary_cell_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_boundary_cell_detector
// Obstacle boundary / frontier cell detection on a raster occupancy grid.
// ----------------------------------------------------------------------------
// The grid enters in raster order, one cell class per item, and every cell
// is decided once, when the item one row and one column after it enters
// (in the last column or row, the item below or to its right; the final
// cell by its own item). A cell is taken in every cycle while the decision
// queue has room; each decision then leaves through the output register at
// one per cycle while the output is ready, so the sustained rate is set by
// the output port: an item decides at most two cells, the final one four.
// The row memory holds one {upper, middle} entry per column and is read and
// written back once per item; it needs no clearing after reset, since rows
// above the grid are masked. Configure only between frames.
// ----------------------------------------------------------------------------
module grid_boundary_cell_detector #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_wr_en,
    input  wire [1:0]                    cfg_index,
    input  wire [gbcd_pkg::CFG_W-1:0]    cfg_data,
    gbcd_in_if.sink                      cells,
    gbcd_out_if.source                   decisions
);
    import gbcd_pkg::*;

    logic             mode_reg;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    cfg_t             cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OBSTACLE;
            rows_reg <= CFG_W'(1024);
            cols_reg <= CFG_W'(1024);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MODE: mode_reg <= cfg_data[0];
                CFG_ROWS: rows_reg <= cfg_data;
                CFG_COLS: cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.mode = mode_reg;
    assign cfg.rows = rows_reg;
    assign cfg.cols = cols_reg;

    logic           push;
    bundle_t        push_data;
    logic           pop;
    logic           q_valid;
    bundle_t        q_data;
    logic [QLW-1:0] queue_level;

    gbcd_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cells       (cells),
        .queue_level (queue_level),
        .push        (push),
        .push_data   (push_data)
    );

    gbcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .level     (queue_level)
    );

    gbcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .decisions (decisions)
    );

endmodule
`default_nettype wire

>>> sim/tb_grid_boundary_cell_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_grid_boundary_cell_detector
// Streams occupancy grids into the detector in raster order, predicts every
// cell decision (hit, position, end markers) and checks each decision item
// in order, with random gaps on the cell side and stalls on the decision side.
// ----------------------------------------------------------------------------
module tb_grid_boundary_cell_detector;
    import gbcd_pkg::*;

    localparam int MAX_ROWS     = 1024;
    localparam int MAX_COLS     = 1024;
    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic             MODE_FRONTIER = 1'b1;
    localparam logic [1:0]       CFG_UNUSED    = 2'd3;
    localparam logic [CLS_W-1:0] CLS_POS       = 2'd1;
    localparam logic [CLS_W-1:0] CLS_NEG       = 2'd2;
    localparam logic [CLS_W-1:0] CLS_NEG_ALT   = 2'd3;

    // neighbour offsets, clockwise from the right
    localparam int NB_DR [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    localparam int NB_DC [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

    typedef struct packed {
        logic             hit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             run_last;
        logic             frame_end;
    } cell_decision_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    gbcd_in_if  cells_if ();
    gbcd_out_if dec_if ();

    grid_boundary_cell_detector #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cells_if),
        .decisions (dec_if)
    );

    // predictor state
    logic             pred_mode = MODE_OBSTACLE;
    logic [CFG_W-1:0] pred_rows = 11'd1024;
    logic [CFG_W-1:0] pred_cols = 11'd1024;
    logic [CLS_W-1:0] above_row [MAX_COLS];
    logic [CLS_W-1:0] mid_row   [MAX_COLS];
    logic [CLS_W-1:0] win [3][3];
    int               at_row = 0;
    int               at_col = 0;

    cell_decision_t   expected_decisions [$];

    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;
    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int hits_seen     = 0;
    int frames_seen   = 0;
    int cycles        = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t: timeout after %0d cycles, %0d decisions outstanding",
                         $time, cycles, expected_decisions.size());
                $display("tb_grid_boundary_cell_detector failed");
                $finish;
            end
        end
    end

    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [CLS_W-1:0] random_class(int zero_pct);
        int q;
        if ($urandom_range(0, 99) < zero_pct)
            return CLS_ZERO;
        q = $urandom_range(0, 9);
        if (q < 5)
            return CLS_POS;
        if (q < 9)
            return CLS_NEG;
        return CLS_NEG_ALT;
    endfunction

    function automatic int clamp_size(logic [CFG_W-1:0] v, int max_v);
        if (v < 2)
            return 2;
        if (v > max_v)
            return max_v;
        return int'(v);
    endfunction

    function automatic bit class_is_zero(logic [CLS_W-1:0] c);
        return c == CLS_ZERO;
    endfunction

    function automatic bit class_is_neg(logic [CLS_W-1:0] c);
        return c[CLS_NEG_BIT];
    endfunction

    // decide the cell held at window position (wr, wc), grid position (gr, gc)
    function automatic cell_decision_t decide_cell(int wr, int wc, int gr, int gc,
                                                   int rows, int cols, bit fend);
        cell_decision_t d;
        logic [CLS_W-1:0] v;
        bit obstacle;
        int nr, nc, a, b;
        obstacle    = (pred_mode == MODE_OBSTACLE);
        d.hit       = 1'b0;
        d.row       = gr[ROW_W-1:0];
        d.col       = gc[COL_W-1:0];
        d.run_last  = 1'b0;
        d.frame_end = fend;
        if (obstacle ? class_is_zero(win[wr][wc]) : class_is_neg(win[wr][wc]))
        begin
            for (int k = 0; k < 8; k++)
            begin
                nr = gr + NB_DR[k];
                nc = gc + NB_DC[k];
                a  = wr + NB_DR[k];
                b  = wc + NB_DC[k];
                if (nr >= 0 && nr < rows && nc >= 0 && nc < cols &&
                    a >= 0 && a <= 2 && b >= 0 && b <= 2)
                begin
                    v = win[a][b];
                    if (obstacle ? !class_is_zero(v) : class_is_zero(v))
                        d.hit = 1'b1;
                end
            end
        end
        return d;
    endfunction

    task automatic predict_decisions(input logic [CLS_W-1:0] cls);
        int rows, cols, r, c, n;
        bit lc, lr;
        logic [CLS_W-1:0] up, mid;
        cell_decision_t res [NRES];
        rows = clamp_size(pred_rows, MAX_ROWS);
        cols = clamp_size(pred_cols, MAX_COLS);
        r = at_row;
        c = at_col;
        // counters left past the end by a smaller size stick at the last index
        if (c >= cols - 1)
            c = cols - 1;
        if (r >= rows - 1)
            r = rows - 1;
        lc = (c == cols - 1);
        lr = (r == rows - 1);

        up  = above_row[c];
        mid = mid_row[c];
        above_row[c] = mid;
        mid_row[c]   = cls;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = cls;

        n = 0;
        if (r >= 1 && c >= 1)
        begin
            res[n] = decide_cell(1, 1, r - 1, c - 1, rows, cols, 1'b0);
            n++;
        end
        if (r >= 1 && lc)
        begin
            res[n] = decide_cell(1, 2, r - 1, c, rows, cols, 1'b0);
            n++;
        end
        if (lr && c >= 1)
        begin
            res[n] = decide_cell(2, 1, r, c - 1, rows, cols, 1'b0);
            n++;
        end
        if (lr && lc)
        begin
            res[n] = decide_cell(2, 2, r, c, rows, cols, 1'b1);
            n++;
        end
        if (n > 0)
            res[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_decisions = {expected_decisions, res[i]};

        if (lc)
        begin
            at_col = 0;
            at_row = lr ? 0 : r + 1;
        end
        else
        begin
            at_col = c + 1;
            at_row = r;
        end
    endtask

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_cell(input logic [CLS_W-1:0] cls);
        int gap;
        gap = 0;
        if (in_idle_on && $urandom_range(0, 2) == 0)
            gap = gap_length();
        if (gap > 0)
        begin
            cells_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cells_if.valid      <= 1'b1;
        cells_if.cell_class <= cls;
        @(negedge clk);
        while (!cells_if.ready)
            @(negedge clk);
        @(posedge clk);
        predict_decisions(cls);
        items_sent++;
    endtask

    task automatic send_grid(input logic [CLS_W-1:0] grid [$]);
        foreach (grid[i])
            send_cell(grid[i]);
    endtask

    task automatic finish_frame(int zero_pct);
        while (at_row != 0 || at_col != 0)
            send_cell(random_class(zero_pct));
    endtask

    task automatic wait_drained();
        cells_if.valid <= 1'b0;
        while (expected_decisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] mode_data,
                                input logic [CFG_W-1:0] rows_data,
                                input logic [CFG_W-1:0] cols_data,
                                input bit poke_unused = 1'b0);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= mode_data;
        @(posedge clk);
        cfg_index <= CFG_ROWS;
        cfg_data  <= rows_data;
        @(posedge clk);
        cfg_index <= CFG_COLS;
        cfg_data  <= cols_data;
        @(posedge clk);
        if (poke_unused)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= '1;
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        cfg_data  <= '0;
        pred_mode = mode_data[0];
        pred_rows = rows_data;
        pred_cols = cols_data;
    endtask

    task automatic report_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin : check_decisions
        cell_decision_t got, want;
        if (rst_n && dec_if.valid && dec_if.ready)
        begin
            got = '{dec_if.hit, dec_if.cell_row, dec_if.cell_col,
                    dec_if.run_last, dec_if.frame_end};
            results_seen++;
            if (expected_decisions.size() == 0)
            begin
                $display("%0t: unexpected decision, expected none, got %p", $time, got);
                errors++;
            end
            else
            begin
                want = expected_decisions.pop_front();
                report_field("hit", 32'(want.hit), 32'(got.hit));
                report_field("cell_row", 32'(want.row), 32'(got.row));
                report_field("cell_col", 32'(want.col), 32'(got.col));
                report_field("run_last", 32'(want.run_last), 32'(got.run_last));
                report_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
                hits_seen   += int'(want.hit);
                frames_seen += int'(want.frame_end);
            end
        end
    end

    initial
    begin : decision_stall
        int gap;
        dec_if.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_idle_on && $urandom_range(0, 4) == 0)
            begin
                dec_if.ready <= 1'b0;
                gap = gap_length();
                repeat (gap) @(posedge clk);
            end
            dec_if.ready <= 1'b1;
        end
    end

    // reset size, then a shrink part-way through the first row
    task automatic test_default_size_resize();
        logic [CLS_W-1:0] g [$];
        g = '{CLS_ZERO, CLS_POS, CLS_NEG};
        send_grid(g);
        wait_drained();
        write_config({10'd0, MODE_OBSTACLE}, 11'd2, 11'd2);
        g = '{CLS_POS, CLS_ZERO, CLS_NEG};
        send_grid(g);
        wait_drained();
    endtask

    // 2x2 grids, sizes below the minimum, both modes
    task automatic test_tiny_frames();
        logic [CLS_W-1:0] g [$];
        write_config({10'd0, MODE_OBSTACLE}, 11'd2, 11'd2);
        g = '{CLS_ZERO, CLS_ZERO, CLS_ZERO, CLS_ZERO};
        send_grid(g);
        wait_drained();
        write_config(11'h7FF, 11'd0, 11'd1, 1'b1);
        g = '{CLS_NEG, CLS_ZERO, CLS_NEG, CLS_NEG};
        send_grid(g);
        wait_drained();
        write_config({10'd0, MODE_FRONTIER}, 11'd1, 11'd0);
        g = '{CLS_NEG, CLS_NEG, CLS_NEG, CLS_NEG};
        send_grid(g);
        wait_drained();
    endtask

    // class three counts as negative and as nonzero
    task automatic test_class_three();
        logic [CLS_W-1:0] g [$];
        write_config({10'd0, MODE_FRONTIER}, 11'd2, 11'd3);
        g = '{CLS_ZERO, CLS_NEG_ALT, CLS_POS, CLS_NEG, CLS_ZERO, CLS_NEG_ALT};
        send_grid(g);
        wait_drained();
        write_config({10'd0, MODE_OBSTACLE}, 11'd2, 11'd3);
        g = '{CLS_ZERO, CLS_ZERO, CLS_NEG_ALT, CLS_ZERO, CLS_ZERO, CLS_ZERO};
        send_grid(g);
        wait_drained();
    endtask

    // oversize grid shrunk in columns, then in rows, while a frame is open
    task automatic test_mid_frame_resize();
        logic [CFG_W-1:0] m;
        m = {1'b1, 9'd0, MODE_FRONTIER};
        write_config(m, 11'd2047, 11'd2047);
        repeat (5) send_cell(random_class(40));
        wait_drained();
        write_config(m, 11'd2047, 11'd3);
        repeat (5) send_cell(random_class(40));
        wait_drained();
        write_config(m, 11'd2, 11'd3);
        finish_frame(40);
        wait_drained();
    endtask

    // sizes over the maximum, then a shrink to close each frame
    task automatic test_max_extent();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        write_config({10'd0, MODE_OBSTACLE}, 11'd2, 11'd1025);
        repeat (6) send_cell(random_class(50));
        wait_drained();
        write_config({10'd0, MODE_OBSTACLE}, 11'd2, 11'd4);
        finish_frame(50);
        wait_drained();
        write_config({10'd0, MODE_FRONTIER}, 11'd1500, 11'd2);
        repeat (6) send_cell(random_class(50));
        wait_drained();
        write_config({10'd0, MODE_FRONTIER}, 11'd3, 11'd2);
        finish_frame(50);
        wait_drained();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int rows, cols, zero_pct, start;
        logic m;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            rows = $urandom_range(2, 6);
            if ($urandom_range(0, 4) == 0)
                cols = $urandom_range(9, 40);
            else
                cols = $urandom_range(2, 8);
            m = 1'($urandom_range(0, 1));
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            write_config({10'd0, m}, rows[CFG_W-1:0], cols[CFG_W-1:0]);
            zero_pct = $urandom_range(5, 95);
            repeat (rows * cols) send_cell(random_class(zero_pct));
            wait_drained();
        end
    endtask

    initial
    begin : main
        foreach (win[i, j])
            win[i][j] = CLS_ZERO;
        foreach (above_row[i])
        begin
            above_row[i] = CLS_ZERO;
            mid_row[i]   = CLS_ZERO;
        end
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_index           <= CFG_MODE;
        cfg_data            <= '0;
        cells_if.valid      <= 1'b0;
        cells_if.cell_class <= CLS_ZERO;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_size_resize();
        test_tiny_frames();
        test_class_three();
        test_mid_frame_resize();
        test_max_extent();
        test_random_frames();
        wait_drained();

        $display("%0d cells sent, %0d decisions checked (%0d hits) over %0d frames",
                 items_sent, results_seen, hits_seen, frames_seen);
        $display("both modes, grids from 2x2 up to oversize settings, mid-frame resizes");
        if (errors == 0)
            $display("tb_grid_boundary_cell_detector passed");
        else
            $display("tb_grid_boundary_cell_detector failed");
        $finish;
    end

endmodule
`default_nettype wire
